// ===== hdl/vector3_normalize_defines.svh =====
// Assertion macros shared by the vector3_normalize checkers.
// No dependencies; the macros sample on aclk and disable on aresetn low.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
// Same-cycle implication, checked at every rising edge outside reset.
`define V3N_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define V3N_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/v3n_pkg.sv =====
// Shared widths, register codes and result type for vector3_normalize.
// No dependencies; every module of the block imports it.
package v3n_pkg;

    localparam int VEC_W             = 32;
    localparam int NUM_LANES         = 3;
    localparam int UNIT_FRAC         = 30;
    localparam int SUM_W             = 64;
    localparam int ROOT_W            = 32;
    localparam int NUM_W             = 62;
    localparam int QUO_W             = 31;
    localparam int TINY_W            = 16;
    localparam int FLUSH_W           = 31;
    localparam int CFG_DATA_W        = 31;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [TINY_W-1:0]  TINY_RST  = 16'd7;
    localparam logic [FLUSH_W-1:0] FLUSH_RST = 31'd107374;
    localparam logic [QUO_W-1:0]   UNIT_ONE  = 31'h4000_0000;

    typedef enum logic {
        CFG_TINY_MAG  = 1'b0,
        CFG_FLUSH_THR = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] unit_x;
        logic signed [VEC_W-1:0] unit_y;
        logic signed [VEC_W-1:0] unit_z;
        logic [ROOT_W-1:0]       length;
        logic                    tiny_flag;
    } result_t;

endpackage

// ===== hdl/v3n_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on v3n_pkg; side data travels alongside each radicand.
module v3n_sqrt import v3n_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W-1:0] valid_reg;
    logic [SUM_W-1:0]  rad_reg   [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_step
        logic [SUM_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_prev;
        logic              ge;

        if (k == 0) begin : g_first
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh       = {rem_prev[REM_W-3:0], rad_prev[2*(ROOT_W-1-k)+1 -: 2]};
        assign trial        = {1'b0, root_prev, 2'b01};
        assign ge           = (rem_sh >= trial);
        assign rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next[k] = {root_prev[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_rad;
            side_reg[0] <= in_side;
            for (int i = 1; i < ROOT_W; i++) begin
                rad_reg[i]  <= rad_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hdl/v3n_div.sv =====
// Pipelined restoring divider, three numerators over one shared divisor,
// one quotient bit per stage after an overflow check. Depends on v3n_pkg.
module v3n_div import v3n_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [NUM_LANES-1:0][NUM_W-1:0]     in_num,
    input  logic [ROOT_W-1:0]                   in_div,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic [NUM_LANES-1:0][QUO_W-1:0]     out_quo,
    output logic [NUM_LANES-1:0]                out_sat,
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int STAGES = QUO_W + 1;

    logic [STAGES-1:0]                  valid_reg;
    logic [NUM_LANES-1:0][QUO_W-1:0]    lo_reg   [STAGES];
    logic [NUM_LANES-1:0][QUO_W-1:0]    lo_next  [STAGES];
    logic [NUM_LANES-1:0][ROOT_W:0]     rem_reg  [STAGES];
    logic [NUM_LANES-1:0][ROOT_W:0]     rem_next [STAGES];
    logic [NUM_LANES-1:0][QUO_W-1:0]    quo_reg  [STAGES];
    logic [NUM_LANES-1:0][QUO_W-1:0]    quo_next [STAGES];
    logic [NUM_LANES-1:0]               sat_reg  [STAGES];
    logic [NUM_LANES-1:0]               sat_next [STAGES];
    logic [ROOT_W-1:0]                  div_reg  [STAGES];
    logic [SIDE_W-1:0]                  side_reg [STAGES];

    genvar k, i;
    for (k = 0; k < STAGES; k++) begin : g_stage
        for (i = 0; i < NUM_LANES; i++) begin : g_lane
            if (k == 0) begin : g_init
                logic [QUO_W-1:0] hi;
                assign hi             = in_num[i][NUM_W-1:QUO_W];
                // quotient would not fit in QUO_W bits: saturate later
                assign sat_next[k][i] = ({1'b0, hi} >= in_div);
                assign rem_next[k][i] = {2'b00, hi};
                assign quo_next[k][i] = '0;
                assign lo_next[k][i]  = in_num[i][QUO_W-1:0];
            end else begin : g_bit
                logic [ROOT_W:0] rem_sh;
                logic            ge;
                assign rem_sh = {rem_reg[k-1][i][ROOT_W-1:0], lo_reg[k-1][i][QUO_W-k]};
                assign ge     = (rem_sh >= {1'b0, div_reg[k-1]});
                assign rem_next[k][i] = ge ? (rem_sh - {1'b0, div_reg[k-1]}) : rem_sh;
                assign quo_next[k][i] = {quo_reg[k-1][i][QUO_W-2:0], ge};
                assign sat_next[k][i] = sat_reg[k-1][i];
                assign lo_next[k][i]  = lo_reg[k-1][i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0]  <= in_div;
            side_reg[0] <= in_side;
            for (int s = 1; s < STAGES; s++) begin
                div_reg[s]  <= div_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            lo_reg  <= lo_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_sat   = sat_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== hdl/vector3_normalize.sv =====
// Top level of vector3_normalize: squares, square root, divider, output buffer.
// Depends on v3n_pkg, v3n_sqrt and v3n_div.
//
// Normalizes one signed fixed-point 3D vector per item (FRACTION_BITS fraction
// bits, Q16.16 by default) and returns the floored Euclidean length plus the
// unit vector in signed Q2.30, rounded to nearest with ties away from zero and
// saturated to +-1.0. A length at or below tiny_magnitude (register 0) selects
// a divisor of 1.0, so the components come out rescaled, and sets tiny_flag.
// Any unit component whose magnitude is below flush_threshold (register 1) is
// forced to zero. Write registers only while the block holds no item.
// Throughput is one item per clock; from acceptance to m_valid an item passes
// the input register, squares, sum, 32 square-root stages (one root bit
// each), divisor setup, 32 divider stages (overflow check then one quotient
// bit each) and the output register. A two-entry output buffer takes the next
// item while a finished one waits; s_ready drops only when both entries are
// full, and the whole pipeline holds until the output drains.
module vector3_normalize import v3n_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VEC_W-1:0] s_vec_x,
    input  logic signed [VEC_W-1:0] s_vec_y,
    input  logic signed [VEC_W-1:0] s_vec_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VEC_W-1:0] m_unit_x,
    output logic signed [VEC_W-1:0] m_unit_y,
    output logic signed [VEC_W-1:0] m_unit_z,
    output logic [ROOT_W-1:0]       m_length,
    output logic                    m_tiny_flag
);

    localparam logic [ROOT_W-1:0] ONE_LEN = ROOT_W'(1) << FRACTION_BITS;
    localparam int SQ_SIDE_W  = NUM_LANES * (VEC_W + 1);
    localparam int DIV_SIDE_W = NUM_LANES + ROOT_W + 1;

    // ---------------- configuration registers ----------------
    logic [TINY_W-1:0]  tiny_mag_reg;
    logic [FLUSH_W-1:0] flush_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiny_mag_reg  <= TINY_RST;
            flush_thr_reg <= FLUSH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TINY_MAG:  tiny_mag_reg  <= cfg_data[TINY_W-1:0];
                CFG_FLUSH_THR: flush_thr_reg <= cfg_data[FLUSH_W-1:0];
            endcase
        end
    end

    // Global advance: the whole pipeline moves unless the output buffer is full.
    logic en;
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- stage A: magnitude and sign ----------------
    logic [NUM_LANES-1:0][VEC_W-1:0] s_vec;
    logic                            a_valid_reg;
    logic [NUM_LANES-1:0][VEC_W-1:0] a_mag_reg;
    logic [NUM_LANES-1:0]            a_neg_reg;

    assign s_vec[0] = s_vec_x;
    assign s_vec[1] = s_vec_y;
    assign s_vec[2] = s_vec_z;

    // ---------------- stage B: squares ----------------
    logic                            b_valid_reg;
    logic [NUM_LANES-1:0][SUM_W-1:0] b_sq_reg;
    logic [NUM_LANES-1:0][VEC_W-1:0] b_mag_reg;
    logic [NUM_LANES-1:0]            b_neg_reg;
    logic [NUM_LANES-1:0][SUM_W-1:0] sq_next;

    // ---------------- stage C: sum of squares ----------------
    logic                            c_valid_reg;
    logic [SUM_W-1:0]                c_sum_reg;
    logic [NUM_LANES-1:0][VEC_W-1:0] c_mag_reg;
    logic [NUM_LANES-1:0]            c_neg_reg;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            sq_next[i] = a_mag_reg[i] * a_mag_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                a_neg_reg[i] <= s_vec[i][VEC_W-1];
                // most negative input maps to 2^31, which fits unsigned
                a_mag_reg[i] <= s_vec[i][VEC_W-1] ? (~s_vec[i] + VEC_W'(1)) : s_vec[i];
            end
            b_sq_reg  <= sq_next;
            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_mag_reg <= b_mag_reg;
            c_neg_reg <= b_neg_reg;
        end
    end

    // ---------------- square root ----------------
    logic                            sq_valid;
    logic [ROOT_W-1:0]               sq_root;
    logic [SQ_SIDE_W-1:0]            sq_side;
    logic [NUM_LANES-1:0][VEC_W-1:0] sq_mag;
    logic [NUM_LANES-1:0]            sq_neg;

    v3n_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rad    (c_sum_reg),
        .in_side   ({c_neg_reg, c_mag_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign {sq_neg, sq_mag} = sq_side;

    // ---------------- stage D: tiny test, divisor, rounded numerators ----------------
    logic                            tiny;
    logic [ROOT_W-1:0]               divisor;
    logic [NUM_LANES-1:0][NUM_W-1:0] num_next;
    logic                            d_valid_reg;
    logic [NUM_LANES-1:0][NUM_W-1:0] d_num_reg;
    logic [ROOT_W-1:0]               d_div_reg;
    logic [DIV_SIDE_W-1:0]           d_side_reg;

    always_comb begin
        tiny    = (sq_root <= {{(ROOT_W-TINY_W){1'b0}}, tiny_mag_reg});
        divisor = tiny ? ONE_LEN : sq_root;
        // |v| * 2^30 plus half the divisor: rounds half away from zero
        for (int i = 0; i < NUM_LANES; i++) begin
            num_next[i] = {sq_mag[i], {UNIT_FRAC{1'b0}}}
                        + {{(NUM_W-ROOT_W+1){1'b0}}, divisor[ROOT_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_num_reg  <= num_next;
            d_div_reg  <= divisor;
            d_side_reg <= {sq_neg, sq_root, tiny};
        end
    end

    // ---------------- divider ----------------
    logic                            dv_valid;
    logic [NUM_LANES-1:0][QUO_W-1:0] dv_quo;
    logic [NUM_LANES-1:0]            dv_sat;
    logic [DIV_SIDE_W-1:0]           dv_side;
    logic [NUM_LANES-1:0]            dv_neg;
    logic [ROOT_W-1:0]               dv_len;
    logic                            dv_tiny;

    v3n_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_div    (d_div_reg),
        .in_side   (d_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sat   (dv_sat),
        .out_side  (dv_side)
    );

    assign {dv_neg, dv_len, dv_tiny} = dv_side;

    // ---------------- saturate, flush, apply sign ----------------
    logic [NUM_LANES-1:0][VEC_W-1:0] unit;
    result_t                         res_in;

    always_comb begin
        logic [QUO_W-1:0] q;
        for (int i = 0; i < NUM_LANES; i++) begin
            q = (dv_sat[i] || (dv_quo[i] > UNIT_ONE)) ? UNIT_ONE : dv_quo[i];
            if (q < flush_thr_reg) begin
                q = '0;
            end
            unit[i] = dv_neg[i] ? (~{1'b0, q} + VEC_W'(1)) : {1'b0, q};
        end
        res_in.unit_x    = unit[0];
        res_in.unit_y    = unit[1];
        res_in.unit_z    = unit[2];
        res_in.length    = dv_len;
        res_in.tiny_flag = dv_tiny;
    end

    // ---------------- two-entry output buffer ----------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    push;
    logic    pop;

    assign push = en && dv_valid;
    assign pop  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            // output slot frees: drain the skid entry first, else take the new item
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            // output held: park the new item
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : res_in;
        end else if (push) begin
            skid_reg <= res_in;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_unit_x    = out_reg.unit_x;
    assign m_unit_y    = out_reg.unit_y;
    assign m_unit_z    = out_reg.unit_z;
    assign m_length    = out_reg.length;
    assign m_tiny_flag = out_reg.tiny_flag;

endmodule

// ===== hdl/v3n_checker.sv =====
// Port-level checks for vector3_normalize, bound to the top level.
// Depends on v3n_pkg and vector3_normalize_defines.svh.
`include "vector3_normalize_defines.svh"

module v3n_checker import v3n_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VEC_W-1:0] m_unit_x,
    input logic signed [VEC_W-1:0] m_unit_y,
    input logic signed [VEC_W-1:0] m_unit_z,
    input logic [ROOT_W-1:0]       m_length,
    input logic                    m_tiny_flag
);

    // a stalled item holds
    `V3N_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_length) && $stable(m_unit_x) && $stable(m_unit_y) && $stable(m_unit_z) && $stable(m_tiny_flag), "stalled result changed")

    // input stalls only when a result is pending at the output
    `V3N_ASSERT_IMPLY(a_stall_cause, !s_ready, m_valid, "input stalled with no result pending")

    // unit components stay within +-1.0
    `V3N_ASSERT_IMPLY(a_unit_range, m_valid, (m_unit_x <= 32'sd1073741824) && (m_unit_x >= -32'sd1073741824) && (m_unit_y <= 32'sd1073741824) && (m_unit_y >= -32'sd1073741824) && (m_unit_z <= 32'sd1073741824) && (m_unit_z >= -32'sd1073741824), "unit component out of range")

    // a zero length comes only from a zero vector, which is always tiny
    `V3N_ASSERT_IMPLY(a_zero_len, m_valid && (m_length == 32'd0), m_tiny_flag && (m_unit_x == 32'sd0) && (m_unit_y == 32'sd0) && (m_unit_z == 32'sd0), "zero length with nonzero result")

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (.*);
